[sv/pwiz_pkg.sv]
package pwiz_pkg;

  localparam int unsigned MeasW    = 16;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned DtW      = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned IntegW   = 40;
  localparam int unsigned DriveW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 40;
  localparam int unsigned MulAW    = 18;
  localparam int unsigned MulBW    = 21;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned AccW     = 57;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETPOINT,
    REG_GAIN_PROP,
    REG_GAIN_INTEG,
    REG_GAIN_DERIV,
    REG_INTEG_ZONE,
    REG_INTEG_MIN,
    REG_INTEG_MAX,
    REG_LOOP_EN
  } pwiz_reg_e;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_RESYNC = 2'd1,
    ACT_CLEAR  = 2'd2
  } pwiz_action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRAP,
    ST_SUM,
    ST_CLAMP,
    ST_PROP,
    ST_DERIV,
    ST_ILO,
    ST_IHI,
    ST_FIN,
    ST_OUT
  } pwiz_state_e;

  typedef struct packed {
    logic signed [GainW-1:0]  setpoint;
    logic signed [GainW-1:0]  gain_prop;
    logic signed [GainW-1:0]  gain_integ;
    logic signed [GainW-1:0]  gain_deriv;
    logic        [GainW-1:0]  integral_zone;
    logic signed [IntegW-1:0] integral_min;
    logic signed [IntegW-1:0] integral_max;
    logic                     loop_enabled;
  } pwiz_cfg_t;

endpackage

[sv/pwiz_regs.sv]
module pwiz_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [pwiz_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pwiz_pkg::CfgDataW-1:0] cfg_data_i,
  output pwiz_pkg::pwiz_cfg_t           cfg_o
);
  import pwiz_pkg::*;

  pwiz_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (pwiz_reg_e'(cfg_index_i))
        REG_SETPOINT:   cfg_q.setpoint      <= cfg_data_i[GainW-1:0];
        REG_GAIN_PROP:  cfg_q.gain_prop     <= cfg_data_i[GainW-1:0];
        REG_GAIN_INTEG: cfg_q.gain_integ    <= cfg_data_i[GainW-1:0];
        REG_GAIN_DERIV: cfg_q.gain_deriv    <= cfg_data_i[GainW-1:0];
        REG_INTEG_ZONE: cfg_q.integral_zone <= cfg_data_i[GainW-1:0];
        REG_INTEG_MIN:  cfg_q.integral_min  <= cfg_data_i[IntegW-1:0];
        REG_INTEG_MAX:  cfg_q.integral_max  <= cfg_data_i[IntegW-1:0];
        REG_LOOP_EN:    cfg_q.loop_enabled  <= cfg_data_i[0];
        default:        cfg_q               <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/pwiz_mul.sv]
module pwiz_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [pwiz_pkg::MulAW-1:0]  a_i,
  input  logic signed [pwiz_pkg::MulBW-1:0]  b_i,
  output logic signed [pwiz_pkg::ProdW-1:0]  prod_o
);
  import pwiz_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(a_i * b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

[sv/pid_with_integral_zone.sv]
// Channel   Direction  Signals
// ------    ---------  ------------------------------------------------
// in        sink       in_valid_i / in_ready_o, action_i, measurement_i,
//                      elapsed_time_i
// out       source     out_valid_o / out_ready_i, drive_o
// cfg       sink       cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i
//
// An enabled control sample steps through TRAP, SUM and CLAMP (only when the
// error is inside the integral zone), PROP, DERIV, ILO, IHI, FIN and OUT, and
// the next item is accepted once the sequencer is back in idle. Resync,
// clear and disabled samples are handled in idle and produce no result.
// All products go through one registered 18x21 multiplier, one per cycle.
// in_ready_o is high only in the idle state; a result waiting in the output
// register stalls the sequencer in its last step. Reset clears the state,
// the integrator, config, previous-sample and output-valid registers to zero.
module pid_with_integral_zone (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic signed [pwiz_pkg::MeasW-1:0]   measurement_i,
  input  logic [pwiz_pkg::DtW-1:0]            elapsed_time_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pwiz_pkg::DriveW-1:0]  drive_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pwiz_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pwiz_pkg::CfgDataW-1:0]       cfg_data_i
);
  import pwiz_pkg::*;

  pwiz_cfg_t   cfg;
  pwiz_state_e state_q, state_d;

  logic signed [MeasW-1:0]  meas_q, prev_meas_q;
  logic        [DtW-1:0]    dt_q;
  logic signed [ErrW-1:0]   err_q, prev_err_q, err_in;
  logic signed [IntegW-1:0] integ_q, integ_sat;
  logic signed [AccW-1:0]   acc_q, prod_ext;
  logic signed [DriveW-1:0] drive_q, drive_sat;
  logic                     out_valid_q;

  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;
  logic                     mul_en;

  logic                     in_fire, out_load, in_zone;
  logic        [ErrW-1:0]   abs_err;
  logic signed [ErrW-1:0]   dmeas;
  logic signed [IntegW:0]   integ_sum;
  logic        [AccW-48:0]  acc_top;

  pwiz_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pwiz_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  assign err_in  = {cfg.setpoint[GainW-1], cfg.setpoint}
                 - {measurement_i[MeasW-1], measurement_i};
  assign abs_err = err_q[ErrW-1] ? ErrW'(-err_q) : ErrW'(err_q);
  assign in_zone = (cfg.integral_zone != '0) && (abs_err < {1'b0, cfg.integral_zone});
  assign dmeas   = {meas_q[MeasW-1], meas_q} - {prev_meas_q[MeasW-1], prev_meas_q};

  assign prod_ext = {{(AccW-ProdW){prod[ProdW-1]}}, prod};

  // saturating integrator add of floor(product / 2)
  assign integ_sum = {integ_q[IntegW-1], integ_q}
                   + {{3{prod[ProdW-1]}}, prod[ProdW-1:1]};
  always_comb begin
    if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
      integ_sat = integ_sum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                    : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[IntegW-1:0];
    end
  end

  assign acc_top = acc_q[AccW-1:47];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      drive_sat = acc_q[47:16];
    end else begin
      drive_sat = acc_q[AccW-1] ? {1'b1, {(DriveW-1){1'b0}}}
                                : {1'b0, {(DriveW-1){1'b1}}};
    end
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_q)
      ST_TRAP: begin
        mul_a = {err_q[ErrW-1], err_q} + {prev_err_q[ErrW-1], prev_err_q};
        mul_b = {{(MulBW-DtW){1'b0}}, dt_q};
      end
      ST_PROP: begin
        mul_a = {{(MulAW-GainW){cfg.gain_prop[GainW-1]}}, cfg.gain_prop};
        mul_b = {{(MulBW-ErrW){err_q[ErrW-1]}}, err_q};
      end
      ST_DERIV: begin
        mul_a = {{(MulAW-GainW){cfg.gain_deriv[GainW-1]}}, cfg.gain_deriv};
        mul_b = {{(MulBW-ErrW){dmeas[ErrW-1]}}, dmeas};
      end
      ST_ILO: begin
        mul_a = {{(MulAW-GainW){cfg.gain_integ[GainW-1]}}, cfg.gain_integ};
        mul_b = {1'b0, integ_q[19:0]};
      end
      ST_IHI: begin
        mul_a = {{(MulAW-GainW){cfg.gain_integ[GainW-1]}}, cfg.gain_integ};
        mul_b = {integ_q[IntegW-1], integ_q[IntegW-1:20]};
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (action_i == ACT_SAMPLE) && cfg.loop_enabled) begin
          state_d = ST_TRAP;
        end
      end
      ST_TRAP:  state_d = in_zone ? ST_SUM : ST_PROP;
      ST_SUM:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_PROP;
      ST_PROP:  state_d = ST_DERIV;
      ST_DERIV: state_d = ST_ILO;
      ST_ILO:   state_d = ST_IHI;
      ST_IHI:   state_d = ST_FIN;
      ST_FIN:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_meas_q <= '0;
      prev_err_q  <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        priority case (action_i)
          ACT_RESYNC: prev_err_q <= err_in;
          ACT_CLEAR:  integ_q    <= '0;
          ACT_SAMPLE: begin
            if (!cfg.loop_enabled) begin
              prev_err_q <= err_in;
            end
          end
          default: ;
        endcase
      end
      if (state_q == ST_SUM) begin
        integ_q <= integ_sat;
      end
      if ((state_q == ST_CLAMP) && (cfg.integral_min < cfg.integral_max)) begin
        if (integ_q < cfg.integral_min) begin
          integ_q <= cfg.integral_min;
        end else if (integ_q > cfg.integral_max) begin
          integ_q <= cfg.integral_max;
        end
      end
      if (out_load) begin
        prev_meas_q <= meas_q;
        prev_err_q  <= err_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      meas_q <= measurement_i;
      dt_q   <= elapsed_time_i;
      err_q  <= err_in;
    end
    unique case (state_q)
      ST_DERIV: acc_q <= prod_ext <<< 16;
      ST_ILO:   acc_q <= acc_q + (prod_ext <<< 16);
      ST_IHI:   acc_q <= acc_q + prod_ext;
      ST_FIN:   acc_q <= acc_q + (prod_ext <<< 20);
      default:  acc_q <= acc_q;
    endcase
    if (out_load) begin
      drive_q <= drive_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule
